// File: rtl/core/bf24_float_adder_macros.svh
// assertion macros used by the float adder
`ifndef BF24_FLOAT_ADDER_MACROS_SVH
`define BF24_FLOAT_ADDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BF24_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BF24_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bf24_pkg.sv
package bf24_pkg;

	localparam int unsigned WORD_W  = 24;
	localparam int unsigned MANT_W  = 15;
	localparam int unsigned EXP_W   = 8;
	localparam int unsigned SIG_W   = 16;
	localparam int unsigned ALIGN_W = 32;
	localparam int unsigned SUM_W   = 33;
	localparam int unsigned LEAD_W  = 6;

	localparam logic [WORD_W-1:0] NEG_ZERO  = 24'h800000;
	localparam logic [WORD_W-1:0] QNAN_OUT  = 24'h7fffff;
	localparam logic [EXP_W-1:0]  EXP_MAX   = 8'hff;
	localparam logic [LEAD_W-1:0] SHIFT_CAP = 6'd32;
	localparam logic              ZERO_MODE_RESET = 1'b1;

	// normalized result kind
	typedef enum logic {
		CLS_PLAIN,
		CLS_ROUND
	} norm_cls_t;

	// normalizer result handed to the rounding stage
	typedef struct packed {
		norm_cls_t          cls;
		logic [EXP_W-1:0]   exp;
		logic [SIG_W-1:0]   man;
		logic               rnd;
	} norm_t;

endpackage

// File: rtl/core/bf24_if.sv
// operand pair request channel
interface bf24_in_if;
	logic                          valid;
	logic                          ready;
	logic [bf24_pkg::WORD_W-1:0]   a_operand;
	logic [bf24_pkg::WORD_W-1:0]   b_operand;
	modport source (output valid, a_operand, b_operand, input ready);
	modport sink (input valid, a_operand, b_operand, output ready);
endinterface

// sum result channel
interface bf24_out_if;
	logic                          valid;
	logic                          ready;
	logic [bf24_pkg::WORD_W-1:0]   sum_result;
	modport source (output valid, sum_result, input ready);
	modport sink (input valid, sum_result, output ready);
endinterface

// File: rtl/core/bf24_norm.sv
module bf24_norm (
	input  logic [bf24_pkg::SUM_W-1:0] rs,
	input  logic [bf24_pkg::EXP_W-1:0] rexp,
	output bf24_pkg::norm_t            norm
);

	logic [bf24_pkg::LEAD_W-1:0] lead;
	logic signed [9:0]           e;
	logic [4:0]                  drop;
	logic [bf24_pkg::SUM_W-1:0]  shifted;
	logic [bf24_pkg::SUM_W-1:0]  stick_mask;
	logic [bf24_pkg::EXP_W-1:0]  dsh;
	logic [14:0]                 dman;
	logic [bf24_pkg::SIG_W-1:0]  lman;

	// leading one position
	always_comb begin
		lead = '0;
		for (int i = 1; i < bf24_pkg::SUM_W; i++) begin
			if (rs[i]) lead = bf24_pkg::LEAD_W'(i);
		end
	end

	// normalize and prepare rounding
	always_comb begin
		e          = $signed({2'b00, rexp}) + $signed({4'b0000, lead}) - 10'sd31;
		drop       = 5'(lead - 6'd15);
		shifted    = rs >> drop;
		stick_mask = (33'd1 << (drop - 5'd1)) - 33'd1;
		dsh        = rexp - 8'd1;
		dman       = (dsh < 8'd15) ? 15'(rs[30:16] << dsh[3:0]) : 15'd0;
		lman       = 16'(rs[15:0] << (6'd15 - lead));
		norm.cls   = bf24_pkg::CLS_PLAIN;
		norm.exp   = '0;
		norm.man   = '0;
		norm.rnd   = 1'b0;
		if (lead == '0) begin
			norm.man = rs[15:0];
		end else if (e <= 10'sd0) begin
			norm.man = {1'b0, dman};
		end else if (e >= 10'sd255) begin
			norm.exp = bf24_pkg::EXP_MAX;
			norm.man = 16'h8000;
		end else if (lead > 6'd15) begin
			norm.cls = bf24_pkg::CLS_ROUND;
			norm.exp = e[7:0];
			norm.man = shifted[15:0];
			norm.rnd = rs[drop - 5'd1] & ((|(rs & stick_mask)) | shifted[0]);
		end else begin
			norm.exp = e[7:0];
			norm.man = lman;
		end
	end

endmodule

// File: rtl/core/bf24_float_adder.sv
// bf24 float adder: adds two 24-bit floats (sign, 8-bit exponent, 15-bit mantissa) with
// round to nearest even. Five register stages (decode, align, add, normalize, round/pack);
// one operand pair is taken every cycle while the output is not stalled, and its sum
// leaves through the stage 5 register. The whole pipeline advances together, so a stall at the
// output holds every stage in place.
// zero_rule_mode (reset 1) makes a minus zero partner of a plus zero operand give plus zero.
`include "bf24_float_adder_macros.svh"

module bf24_float_adder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data,
	bf24_in_if.sink                       in_ch,
	bf24_out_if.source                    out_ch
);

	logic zero_rule_mode_q;
	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic                         sp_s1, sp_s2, sp_s3, sp_s4;
	logic [bf24_pkg::WORD_W-1:0]  spv_s1, spv_s2, spv_s3, spv_s4;
	logic                         sbig_s1, sbig_s2;
	logic                         ssml_s1, ssml_s2;
	logic [bf24_pkg::SIG_W-1:0]   big_s1, big_s2;
	logic [bf24_pkg::SIG_W-1:0]   sml_s1;
	logic [bf24_pkg::ALIGN_W-1:0] sml_s2;
	logic [bf24_pkg::LEAD_W-1:0]  sh_s1;
	logic [bf24_pkg::EXP_W-1:0]   rexp_s1, rexp_s2, rexp_s3;
	logic [bf24_pkg::SUM_W-1:0]   rs_s3;
	logic                         rb_s3, rb_s4;
	bf24_pkg::norm_t              norm_s4;
	logic [bf24_pkg::WORD_W-1:0]  sum_s5;

	// decode signals
	logic [bf24_pkg::WORD_W-1:0]  a, b;
	logic [bf24_pkg::EXP_W-1:0]   ea, eb, eae, ebe, diff;
	logic                         a_ge, nan_a, nan_b;
	logic                         sp_d;
	logic [bf24_pkg::WORD_W-1:0]  spv_d;
	logic [bf24_pkg::ALIGN_W-1:0] big32;
	logic [bf24_pkg::SUM_W-1:0]   rs_d;
	logic                         rb_d;
	bf24_pkg::norm_t              norm_d;
	logic [bf24_pkg::SIG_W:0]     rnd_sum;
	logic [bf24_pkg::EXP_W-1:0]   fexp;
	logic [bf24_pkg::SIG_W-1:0]   fman;

	// whole pipeline moves when the output slot frees up
	assign adv          = !v_s5 || out_ch.ready;
	assign in_ch.ready  = adv;
	assign out_ch.valid = v_s5;
	assign out_ch.sum_result = sum_s5;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_rule_mode_q <= bf24_pkg::ZERO_MODE_RESET;
		end else if (cfg_wr_en) begin
			zero_rule_mode_q <= cfg_wr_data;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: decode, special cases, exponent difference
	always_comb begin
		a     = in_ch.a_operand;
		b     = in_ch.b_operand;
		ea    = a[22:15];
		eb    = b[22:15];
		eae   = (ea == '0) ? 8'd1 : ea;
		ebe   = (eb == '0) ? 8'd1 : eb;
		a_ge  = eae >= ebe;
		diff  = a_ge ? (eae - ebe) : (ebe - eae);
		nan_a = (ea == bf24_pkg::EXP_MAX) && (a[14:0] != '0);
		nan_b = (eb == bf24_pkg::EXP_MAX) && (b[14:0] != '0);
		sp_d  = 1'b1;
		spv_d = '0;
		if (a == '0) begin
			spv_d = (zero_rule_mode_q && b == bf24_pkg::NEG_ZERO) ? '0 : b;
		end else if (b == '0) begin
			spv_d = (zero_rule_mode_q && a == bf24_pkg::NEG_ZERO) ? '0 : a;
		end else if (nan_a || nan_b) begin
			spv_d = bf24_pkg::QNAN_OUT;
		end else if (ea == bf24_pkg::EXP_MAX && eb == bf24_pkg::EXP_MAX && a[23] != b[23]) begin
			spv_d = bf24_pkg::QNAN_OUT;
		end else if (ea == bf24_pkg::EXP_MAX) begin
			spv_d = a;
		end else if (eb == bf24_pkg::EXP_MAX) begin
			spv_d = b;
		end else begin
			sp_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s1   <= sp_d;
			spv_s1  <= spv_d;
			sbig_s1 <= a_ge ? a[23] : b[23];
			ssml_s1 <= a_ge ? b[23] : a[23];
			big_s1  <= a_ge ? {ea != '0, a[14:0]} : {eb != '0, b[14:0]};
			sml_s1  <= a_ge ? {eb != '0, b[14:0]} : {ea != '0, a[14:0]};
			rexp_s1 <= a_ge ? eae : ebe;
			sh_s1   <= (diff > 8'(bf24_pkg::SHIFT_CAP)) ? bf24_pkg::SHIFT_CAP : diff[5:0];
		end
	end

	// stage 2: align the smaller operand
	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s2   <= sp_s1;
			spv_s2  <= spv_s1;
			sbig_s2 <= sbig_s1;
			ssml_s2 <= ssml_s1;
			big_s2  <= big_s1;
			sml_s2  <= {sml_s1, 16'h0000} >> sh_s1;
			rexp_s2 <= rexp_s1;
		end
	end

	// stage 3: add or subtract magnitudes
	always_comb begin
		big32 = {big_s2, 16'h0000};
		if (sbig_s2 == ssml_s2) begin
			rs_d = {1'b0, big32} + {1'b0, sml_s2};
			rb_d = sbig_s2;
		end else if (big32 > sml_s2) begin
			rs_d = {1'b0, big32 - sml_s2};
			rb_d = sbig_s2;
		end else if (big32 < sml_s2) begin
			rs_d = {1'b0, sml_s2 - big32};
			rb_d = ssml_s2;
		end else begin
			rs_d = '0;
			rb_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s3   <= sp_s2;
			spv_s3  <= spv_s2;
			rs_s3   <= rs_d;
			rb_s3   <= rb_d;
			rexp_s3 <= rexp_s2;
		end
	end

	// stage 4: normalize
	bf24_norm u_norm (
		.rs   (rs_s3),
		.rexp (rexp_s3),
		.norm (norm_d)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s4   <= sp_s3;
			spv_s4  <= spv_s3;
			rb_s4   <= rb_s3;
			norm_s4 <= norm_d;
		end
	end

	// stage 5: round and pack
	always_comb begin
		rnd_sum = {1'b0, norm_s4.man} + {16'h0000, norm_s4.rnd};
		fexp    = norm_s4.exp;
		fman    = norm_s4.man;
		if (norm_s4.cls == bf24_pkg::CLS_ROUND) begin
			if (rnd_sum[16]) begin
				fman = rnd_sum[16:1];
				fexp = norm_s4.exp + 8'd1;
			end else begin
				fman = rnd_sum[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s5 <= sp_s4 ? spv_s4 : {rb_s4, fexp, fman[14:0]};
		end
	end

	// pipeline checks
	`BF24_ASSERT_NEXT(a_s1_to_s2, adv && v_s1, v_s2, "stage 1 item lost on advance")
	`BF24_ASSERT_NEXT(a_stall_hold, !adv, $stable(v_s4) && $stable(sum_s5), "stall moved pipeline")
	`BF24_ASSERT_NOW(a_inf_round, v_s4 && !sp_s4 && norm_s4.exp == bf24_pkg::EXP_MAX,
		norm_s4.cls == bf24_pkg::CLS_PLAIN, "overflow path reached rounding")

endmodule
